// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tick scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ===== rtl/tsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Tick scheduler package
// Types and constants shared by the tick scheduler with beeper modules.
// ----------------------------------------------------------------------------
package tsb_pkg;

    localparam int TICKS_PER_MS_DEFAULT = 10;
    localparam int QUEUE_DEPTH          = 2;
    localparam int QUEUE_PTR_W          = 1;
    localparam int QUEUE_CNT_W          = 2;

    typedef enum logic [2:0] {
        OP_TICK           = 3'd0,
        OP_BEEP           = 3'd1,
        OP_SET_DEADLINE   = 3'd2,
        OP_CHECK_DEADLINE = 3'd3,
        OP_ACK_MOTOR      = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] value;
        logic [15:0] modulation;
    } in_item_t;

    typedef struct packed {
        logic        speaker_on;
        logic        motor_update;
        logic [15:0] millis_now;
        logic [15:0] deadline_out;
        logic        expired;
        logic        compass_strobe;
    } out_item_t;

    // Classified command as passed from the front part to the back part.
    typedef struct packed {
        logic        tick;
        logic        beep;
        logic        set_deadline;
        logic        check_deadline;
        logic        ack_motor;
        logic [15:0] value;
        logic [15:0] modulation;
    } cmd_t;

endpackage

// ===== rtl/tsb_front.sv =====
// ----------------------------------------------------------------------------
// Tick scheduler front end
// Accepts input transactions and registers them as classified commands.
// ----------------------------------------------------------------------------
module tsb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tsb_pkg::in_item_t in_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output tsb_pkg::cmd_t     cmd_data
);
    import tsb_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    assign in_ready = !valid_reg || cmd_ready;

    always_comb
    begin
        cmd_next            = '0;
        cmd_next.value      = in_data.value;
        cmd_next.modulation = in_data.modulation;
        unique case (in_data.operation)
            OP_TICK:           cmd_next.tick           = 1'b1;
            OP_BEEP:           cmd_next.beep           = 1'b1;
            OP_SET_DEADLINE:   cmd_next.set_deadline   = 1'b1;
            OP_CHECK_DEADLINE: cmd_next.check_deadline = 1'b1;
            OP_ACK_MOTOR:      cmd_next.ack_motor      = 1'b1;
            default:           cmd_next.value          = in_data.value;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd_data  = cmd_reg;

endmodule

// ===== rtl/tsb_queue.sv =====
// ----------------------------------------------------------------------------
// Tick scheduler command queue
// Short queue that lets the front and back parts stall independently.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  tsb_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output tsb_pkg::cmd_t pop_data
);
    import tsb_pkg::*;

    cmd_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_IMPLY(a_queue_bound, clk, rst_n, 1'b1, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
    `ASSERT_NEXT(a_queue_pop_seen, clk, rst_n, push && !pop, pop_valid)

endmodule

// ===== rtl/tsb_back.sv =====
// ----------------------------------------------------------------------------
// Tick scheduler back end
// Executes commands against the timer and beeper state and registers results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsb_back #(
    parameter int TICKS_PER_MS = tsb_pkg::TICKS_PER_MS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_data,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  tsb_pkg::cmd_t      cmd_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tsb_pkg::out_item_t out_data
);
    import tsb_pkg::*;

    localparam int DIV_W = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
    localparam logic [DIV_W-1:0] DIV_RELOAD = DIV_W'(TICKS_PER_MS - 1);

    logic             compass_reg;
    logic [DIV_W-1:0] div_reg;
    logic [DIV_W-1:0] div_next;
    logic             phase_reg;
    logic             phase_next;
    logic             flag_reg;
    logic             flag_next;
    logic [15:0]      millis_reg;
    logic [15:0]      millis_next;
    logic [15:0]      remaining_reg;
    logic [15:0]      remaining_next;
    logic [15:0]      mask_reg;
    logic [15:0]      mask_next;
    logic             speaker_reg;
    logic             speaker_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_item_t        out_reg;
    out_item_t        out_next;
    logic             exec;
    logic [15:0]      diff;

    assign cmd_ready = !out_valid_reg || out_ready;
    assign exec      = cmd_valid && cmd_ready;
    assign diff      = cmd_data.value - millis_reg;

    always_comb
    begin
        div_next       = div_reg;
        phase_next     = phase_reg;
        flag_next      = flag_reg;
        millis_next    = millis_reg;
        remaining_next = remaining_reg;
        mask_next      = mask_reg;
        speaker_next   = speaker_reg;
        if (cmd_data.tick)
        begin
            if (div_reg == '0)
            begin
                div_next    = DIV_RELOAD;
                phase_next  = !phase_reg;
                millis_next = millis_reg + 16'd1;
                if (phase_reg)
                begin
                    flag_next = 1'b1;
                end
            end
            else
            begin
                div_next = div_reg - 1'b1;
            end
            if (remaining_reg != '0)
            begin
                remaining_next = remaining_reg - 16'd1;
                speaker_next   = |(remaining_next & mask_reg);
            end
            else
            begin
                speaker_next = 1'b0;
                mask_next    = 16'hFFFF;
            end
        end
        if (cmd_data.beep)
        begin
            remaining_next = cmd_data.value;
            mask_next      = cmd_data.modulation;
        end
        if (cmd_data.ack_motor)
        begin
            flag_next = 1'b0;
        end

        out_next.speaker_on     = speaker_next;
        out_next.motor_update   = flag_next;
        out_next.millis_now     = millis_next;
        out_next.deadline_out   = cmd_data.set_deadline
                                  ? millis_reg + cmd_data.value - 16'd1 : 16'd0;
        out_next.expired        = cmd_data.check_deadline && diff[15];
        out_next.compass_strobe = cmd_data.tick && compass_reg;

        out_valid_next = out_valid_reg;
        if (cmd_ready)
        begin
            out_valid_next = cmd_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compass_reg   <= 1'b0;
            div_reg       <= '0;
            phase_reg     <= 1'b1;
            flag_reg      <= 1'b0;
            millis_reg    <= '0;
            remaining_reg <= '0;
            mask_reg      <= 16'hFFFF;
            speaker_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                compass_reg <= cfg_data;
            end
            if (exec)
            begin
                div_reg       <= div_next;
                phase_reg     <= phase_next;
                flag_reg      <= flag_next;
                millis_reg    <= millis_next;
                remaining_reg <= remaining_next;
                mask_reg      <= mask_next;
                speaker_reg   <= speaker_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `ASSERT_NEXT(a_exec_gives_result, clk, rst_n, exec, out_valid_reg)
    `ASSERT_IMPLY(a_millis_on_tick, clk, rst_n, !$stable(millis_reg),
                  $past(exec) && $past(cmd_data.tick))
    `ASSERT_NEXT(a_beep_loads, clk, rst_n, exec && cmd_data.beep,
                 remaining_reg == $past(cmd_data.value))

endmodule

// ===== rtl/tick_scheduler_with_beeper_top.sv =====
// ----------------------------------------------------------------------------
// Tick scheduler with beeper, top level
// Millisecond prescaler, motor-update flag, beep modulation and deadline maths.
// ----------------------------------------------------------------------------
// Path: a transaction accepted at the input passes the front register, the
// command queue and the result register before its result appears.
// Throughput: one transaction per clock cycle, sustained while the result port
// is ready, as the back end updates its state for each command it executes.
// Reset: rst_n resets all control state and the timer and beeper state at once.
// ----------------------------------------------------------------------------
module tick_scheduler_with_beeper_top #(
    parameter int TICKS_PER_MS = tsb_pkg::TICKS_PER_MS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tsb_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tsb_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import tsb_pkg::*;

    // Front to queue and queue to back handshakes.
    logic fq_valid;
    logic fq_ready;
    cmd_t fq_data;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_data;

    // The compass enable register is a single flop in the back end and can
    // take a write transaction in any cycle.
    assign cfg_ready = 1'b1;

    // The front end decodes the operation code into one flag per command so
    // that the back end only has to look at single bits.
    tsb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd_data  (fq_data)
    );

    // A two-entry queue decouples the two halves, so a stalled result port
    // does not immediately back up into the input port.
    tsb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    // The back end owns all timer and beeper state: prescaler, motor phase and
    // flag, millisecond count, beep countdown and mask, speaker level and compass
    // enable. It executes one command per cycle whenever the result register is free.
    tsb_back #(
        .TICKS_PER_MS (TICKS_PER_MS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd_data  (qb_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tick scheduler with beeper testbench
// A queue-fed driver sends operations with random gaps, a monitor stalls the
// result side at random, predicts every result from its own copy of the timer
// and beeper state and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

    import tsb_pkg::*;

    // Clock period, run limit and the latency constant for the block, which sets
    // the final quiet time together with a small margin.
    localparam int CLK_PERIOD     = 10;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int LATENCY        = 3;
    localparam int TICKS          = TICKS_PER_MS_DEFAULT;
    localparam int PHASE_OPS      = 400;

    // The operation field is three bits wide; codes above the last defined
    // operation must leave the state untouched.
    localparam logic [2:0]  OP_CODE_MAX = 3'd7;
    localparam logic [15:0] ALL_ONES    = 16'hFFFF;
    localparam logic [15:0] HALF_RANGE  = 16'h8000;

    // Entries waiting for the driver: an operation, a register write, or a
    // pause that holds the sender until every expected result has come back.
    typedef enum logic [1:0] {
        ENTRY_OP,
        ENTRY_CFG,
        ENTRY_QUIESCE
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t kind;
        in_item_t    item;
        logic        cfg_bit;
    } pending_entry_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;

    pending_entry_t pending_ops[$];
    out_item_t      expected_status[$];

    // Predicted state of the scheduler, owned by the monitor.
    logic [3:0]  sched_div;
    logic        motor_toggle;
    logic        motor_req;
    logic [15:0] ms_count;
    logic [15:0] beep_left;
    logic [15:0] beep_gate;
    logic        spk_level;
    logic        compass_on;

    // Registered by the monitor so that the driver sees a settled view of
    // whether anything is still outstanding.
    logic idle_q = 1'b1;

    int unsigned status_errors = 0;
    int unsigned results_checked = 0;
    int unsigned cfg_writes = 0;
    int unsigned op_seen[8];

    // Generator bookkeeping: ticks queued so far give a rough idea of the
    // millisecond count, so that deadline checks land close to "now".
    int unsigned gen_ticks = 0;
    int unsigned queued_ops = 0;

    // Driver and monitor working variables.
    pending_entry_t head;
    logic           next_in_valid;
    logic           next_cfg_valid;
    int unsigned    gap_left = 0;
    int unsigned    stall_left = 0;
    logic           tx_calm = 1'b0;
    logic           rx_calm = 1'b0;
    out_item_t      want;

    tick_scheduler_with_beeper_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Applies one operation to the predicted state and returns the status
    // that the block should report for it.
    function automatic out_item_t advance_scheduler(in_item_t item);
        out_item_t   res;
        logic [15:0] diff;
        res = '0;
        case (item.operation)
            OP_TICK:
            begin
                // The prescaler reloads when it is at zero, which is also the
                // moment the millisecond count moves on.
                if (sched_div == 4'd0)
                begin
                    sched_div    = 4'(TICKS - 1);
                    motor_toggle = ~motor_toggle;
                    if (!motor_toggle)
                        motor_req = 1'b1;
                    ms_count = ms_count + 16'd1;
                end
                else
                begin
                    sched_div = sched_div - 4'd1;
                end
                if (beep_left != 16'd0)
                begin
                    beep_left = beep_left - 16'd1;
                    spk_level = |(beep_left & beep_gate);
                end
                else
                begin
                    spk_level = 1'b0;
                    beep_gate = ALL_ONES;
                end
                res.compass_strobe = compass_on;
            end
            OP_BEEP:
            begin
                beep_left = item.value;
                beep_gate = item.modulation;
            end
            OP_SET_DEADLINE:
                res.deadline_out = ms_count + item.value - 16'd1;
            OP_CHECK_DEADLINE:
            begin
                diff        = item.value - ms_count;
                res.expired = diff[15];
            end
            OP_ACK_MOTOR:
                motor_req = 1'b0;
            default:
                ;
        endcase
        res.speaker_on   = spk_level;
        res.motor_update = motor_req;
        res.millis_now   = ms_count;
        return res;
    endfunction

    task automatic check_field(string field, logic [15:0] exp_val, logic [15:0] got_val);
        if (got_val !== exp_val)
        begin
            status_errors++;
            if (status_errors <= 10)
                $display("tb_top: result %0d, %s expected 0x%04h, got 0x%04h",
                         results_checked, field, exp_val, got_val);
        end
    endtask

    task automatic queue_op(logic [2:0] op, logic [15:0] value, logic [15:0] modulation);
        pending_entry_t e;
        e.kind                = ENTRY_OP;
        e.item.operation      = op;
        e.item.value          = value;
        e.item.modulation     = modulation;
        e.cfg_bit             = 1'b0;
        pending_ops.push_back(e);
        if (op == OP_TICK)
            gen_ticks++;
        if (op <= OP_ACK_MOTOR)
            queued_ops++;
    endtask

    task automatic queue_entry(entry_kind_t kind, logic cfg_bit);
        pending_entry_t e;
        e         = '0;
        e.kind    = kind;
        e.cfg_bit = cfg_bit;
        pending_ops.push_back(e);
    endtask

    // Modulation masks: plain, silent, a single bit, alternating, or random.
    function automatic logic [15:0] beep_pattern();
        case ($urandom_range(0, 5))
            0:       return ALL_ONES;
            1:       return 16'h0000;
            2:       return 16'h0001 << $urandom_range(0, 15);
            3:       return ($urandom_range(0, 1) != 0) ? 16'h5555 : 16'hAAAA;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random_op();
        int unsigned r;
        int unsigned now_ms;
        logic [15:0] v;
        r      = $urandom_range(0, 99);
        now_ms = (gen_ticks + TICKS - 1) / TICKS;
        if (r < 45)
        begin
            queue_op(OP_TICK, 16'($urandom), 16'($urandom));
        end
        else if (r < 55)
        begin
            v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
            queue_op(OP_BEEP, v, beep_pattern());
        end
        else if (r < 68)
        begin
            case ($urandom_range(0, 3))
                0:       v = ($urandom_range(0, 1) != 0) ? 16'h0000 : ALL_ONES;
                1:       v = 16'($urandom_range(1, 50));
                default: v = 16'($urandom);
            endcase
            queue_op(OP_SET_DEADLINE, v, 16'($urandom));
        end
        else if (r < 84)
        begin
            // Probe around "now" and around the point half the range away,
            // where the sign of the difference flips.
            case ($urandom_range(0, 2))
                0:       v = 16'(now_ms) + 16'($urandom_range(0, 8)) - 16'd4;
                1:       v = 16'(now_ms) + HALF_RANGE + 16'($urandom_range(0, 4)) - 16'd2;
                default: v = 16'($urandom);
            endcase
            queue_op(OP_CHECK_DEADLINE, v, 16'($urandom));
        end
        else if (r < 96)
        begin
            queue_op(OP_ACK_MOTOR, 16'($urandom), 16'($urandom));
        end
        else
        begin
            queue_op(3'($urandom_range(int'(OP_ACK_MOTOR) + 1, int'(OP_CODE_MAX))),
                     16'($urandom), 16'($urandom));
        end
    endtask

    // A well-formed stretch: start a beep and follow it with ticks, with other
    // operations mixed in; or a burst of ticks that moves the millisecond count
    // and the motor flag along; or else a single random operation.
    task automatic queue_episode();
        logic [15:0] len;
        int unsigned n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                len = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
                queue_op(OP_BEEP, len, beep_pattern());
                n = (len > 16'd28) ? $urandom_range(1, 32) : $urandom_range(1, int'(len) + 4);
                repeat (n)
                begin
                    if ($urandom_range(0, 4) == 0)
                        queue_random_op();
                    else
                        queue_op(OP_TICK, 16'($urandom), 16'($urandom));
                end
            end
            4:
            begin
                repeat ($urandom_range(10, 40))
                    queue_op(OP_TICK, 16'($urandom), 16'($urandom));
            end
            default:
                queue_random_op();
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Driver. Holds a transaction until it is accepted, then takes the next
    // entry once the random gap has run out. Register writes and pauses wait
    // until nothing is in flight: the previous cycle carried no operation
    // and the monitor saw no expected result outstanding.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
            in_data   <= '0;
            cfg_data  <= 1'b0;
            gap_left  = 0;
        end
        else if (!((in_valid && !in_ready) || (cfg_valid && !cfg_ready)))
        begin
            next_in_valid  = 1'b0;
            next_cfg_valid = 1'b0;
            if ($urandom_range(0, 299) == 0)
                tx_calm = !tx_calm;
            if (gap_left != 0)
            begin
                gap_left--;
            end
            else if (pending_ops.size() != 0)
            begin
                head = pending_ops[0];
                case (head.kind)
                    ENTRY_OP:
                    begin
                        in_data       <= head.item;
                        next_in_valid = 1'b1;
                        void'(pending_ops.pop_front());
                        gap_left = tx_calm ? 0 : pick_gap();
                    end
                    ENTRY_CFG:
                    begin
                        if (idle_q && !in_valid)
                        begin
                            cfg_data       <= head.cfg_bit;
                            next_cfg_valid = 1'b1;
                            void'(pending_ops.pop_front());
                            gap_left = tx_calm ? 0 : pick_gap();
                        end
                    end
                    default:
                    begin
                        if (idle_q && !in_valid)
                            void'(pending_ops.pop_front());
                    end
                endcase
            end
            in_valid  <= next_in_valid;
            cfg_valid <= next_cfg_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Everything that depends on handshakes is handled here, in one
    // block, so that the order of updates within an edge is fixed: register
    // writes first, then accepted operations feed the predictor, then an
    // accepted result is compared with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            idle_q       <= 1'b1;
            stall_left   = 0;
            sched_div    = 4'd0;
            motor_toggle = 1'b1;
            motor_req    = 1'b0;
            ms_count     = 16'd0;
            beep_left    = 16'd0;
            beep_gate    = ALL_ONES;
            spk_level    = 1'b0;
            compass_on   = 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                compass_on = cfg_data;
                cfg_writes++;
            end

            if (in_valid && in_ready)
            begin
                expected_status.push_back(advance_scheduler(in_data));
                op_seen[in_data.operation]++;
            end

            if (out_valid && out_ready)
            begin
                if (expected_status.size() == 0)
                begin
                    status_errors++;
                    if (status_errors <= 10)
                        $display("tb_top: result arrived with nothing expected: %h", out_data);
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("speaker_on", 16'(want.speaker_on), 16'(out_data.speaker_on));
                    check_field("motor_update", 16'(want.motor_update),
                                16'(out_data.motor_update));
                    check_field("millis_now", want.millis_now, out_data.millis_now);
                    check_field("deadline_out", want.deadline_out, out_data.deadline_out);
                    check_field("expired", 16'(want.expired), 16'(out_data.expired));
                    check_field("compass_strobe", 16'(want.compass_strobe),
                                16'(out_data.compass_strobe));
                    results_checked++;
                end
            end

            idle_q <= (expected_status.size() == 0);

            // Receiver stalls: stretches of full readiness alternate with
            // stretches of random back-pressure.
            if ($urandom_range(0, 299) == 0)
                rx_calm = !rx_calm;
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!rx_calm && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                out_ready <= (stall_left == 0);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run. The whole schedule is queued up front; the
    // driver then works through it. The run ends once the queue is empty,
    // the sender is quiet and every expected result has been checked.
    // ------------------------------------------------------------------------
    initial
    begin
        logic phase_bit;
        int unsigned target;

        // Directed part, compass strobe off as after reset. The first tick
        // finds the prescaler at zero, so the count and the motor flag move
        // at once.
        queue_op(OP_TICK, 16'h0000, 16'h0000);
        for (int c = int'(OP_ACK_MOTOR) + 1; c <= int'(OP_CODE_MAX); c++)
            queue_op(3'(c), ALL_ONES, ALL_ONES);
        queue_op(OP_ACK_MOTOR, 16'h0000, 16'h0000);
        queue_op(OP_SET_DEADLINE, 16'h0000, ALL_ONES);
        queue_op(OP_SET_DEADLINE, ALL_ONES, 16'h0000);
        queue_op(OP_CHECK_DEADLINE, 16'h0000, 16'h0000);
        queue_op(OP_CHECK_DEADLINE, ALL_ONES, 16'h0000);
        queue_op(OP_CHECK_DEADLINE, HALF_RANGE, 16'h0000);
        queue_op(OP_CHECK_DEADLINE, HALF_RANGE + 16'd1, 16'h0000);
        // A long beep with an all-zero mask stays silent.
        queue_op(OP_BEEP, ALL_ONES, 16'h0000);
        queue_op(OP_TICK, 16'h0000, 16'h0000);
        // A short plain beep runs out and the mask returns to all ones.
        queue_op(OP_BEEP, 16'd3, ALL_ONES);
        repeat (4)
            queue_op(OP_TICK, 16'h0000, 16'h0000);
        // A single-bit mask switches the speaker on as it counts down.
        queue_op(OP_BEEP, 16'd6, 16'h0002);
        repeat (3)
            queue_op(OP_TICK, 16'h0000, 16'h0000);
        // A zero-length beep with an empty mask is cleared by the next tick.
        queue_op(OP_BEEP, 16'h0000, 16'h0000);
        queue_op(OP_TICK, ALL_ONES, ALL_ONES);
        queue_entry(ENTRY_CFG, 1'b1);
        queue_op(OP_TICK, 16'h0000, 16'h0000);
        queue_op(OP_TICK, 16'h0000, 16'h0000);

        // Random part in four phases with the compass strobe alternately off
        // and on, each with a pause in the middle where the sender waits for
        // all outstanding results.
        for (int p = 0; p < 4; p++)
        begin
            phase_bit = (p % 2 == 1);
            queue_entry(ENTRY_CFG, phase_bit);
            target = queued_ops + PHASE_OPS / 2;
            while (queued_ops < target)
                queue_episode();
            queue_entry(ENTRY_QUIESCE, 1'b0);
            target = queued_ops + PHASE_OPS / 2;
            while (queued_ops < target)
                queue_episode();
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Sampled away from the rising edge so that every update of the edge
        // has settled.
        @(negedge clk);
        while (pending_ops.size() != 0 || in_valid || cfg_valid || expected_status.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        $display("tb_top: %0d results checked: %0d ticks, %0d beeps, %0d deadlines formed,",
                 results_checked, op_seen[OP_TICK], op_seen[OP_BEEP], op_seen[OP_SET_DEADLINE]);
        $display("tb_top: %0d deadline checks, %0d acks, %0d register writes, %0d ms reached",
                 op_seen[OP_CHECK_DEADLINE], op_seen[OP_ACK_MOTOR], cfg_writes, ms_count);
        if (status_errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_top: timed out");
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
